[rtl/qfts_pkg.sv]
package qfts_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int DATA_WIDTH_DEF  = 32;
  localparam int CMDQ_DEPTH      = 2;

  localparam logic MODE_DEQ = 1'b1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  typedef struct packed {
    logic        mode;
    logic [31:0] data_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] data_out;
    logic        queue_empty;
  } out_item_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] data;
  } cmd_t;

endpackage

[rtl/qfts_ram.sv]
module qfts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/qfts_front.sv]
module qfts_front
  import qfts_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_item_t in_item,
  output logic     cmd_valid,
  output cmd_t     cmd,
  input  logic     cmd_pop
);

  localparam int QAW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int QCW = $clog2(CMDQ_DEPTH + 1);

  cmd_t           q_r [CMDQ_DEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;
  logic           push;
  logic           pop;
  cmd_t           new_cmd;

  // decode the mode bit into an operation
  always_comb begin
    new_cmd.op   = (in_item.mode == MODE_DEQ) ? OP_DEQ : OP_ENQ;
    new_cmd.data = in_item.data_in;
  end

  assign busy      = (cnt_r == QCW'(CMDQ_DEPTH));
  assign push      = start && !busy;
  assign cmd_valid = (cnt_r != '0);
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QAW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QAW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule

[rtl/qfts_back.sv]
module qfts_back
  import qfts_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_MOVE = 4'b0100,
    S_POP  = 4'b1000
  } state_t;

  state_t          state_r, state_nxt;
  cmd_t            cmd_r, cmd_nxt;
  logic [CW-1:0]   in_cnt_r, in_cnt_nxt;
  logic [CW-1:0]   out_cnt_r, out_cnt_nxt;
  logic            mv_pend_r, mv_pend_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_item_r, out_item_nxt;

  logic            in_we;
  logic [AW-1:0]   in_waddr;
  logic [AW-1:0]   in_raddr;
  logic [DATA_WIDTH-1:0] in_rdata;
  logic            out_we;
  logic [AW-1:0]   out_waddr;
  logic [AW-1:0]   out_raddr;
  logic [DATA_WIDTH-1:0] out_rdata;
  logic [DATA_WIDTH-1:0] enq_data;
  logic [CW-1:0]   in_top;
  logic [CW-1:0]   out_top;
  logic            in_full;

  assign enq_data  = DATA_WIDTH'(cmd_r.data);
  assign in_top    = in_cnt_r - CW'(1);
  assign out_top   = out_cnt_r - CW'(1);
  assign in_raddr  = in_top[AW-1:0];
  assign out_raddr = out_top[AW-1:0];
  assign in_waddr  = in_cnt_r[AW-1:0];
  assign out_waddr = out_cnt_r[AW-1:0];
  assign in_full   = (in_cnt_r == CW'(STACK_DEPTH));

  qfts_ram #(.WIDTH(DATA_WIDTH), .DEPTH(STACK_DEPTH)) u_in_stack (
    .clk   (clk),
    .we    (in_we),
    .waddr (in_waddr),
    .wdata (enq_data),
    .raddr (in_raddr),
    .rdata (in_rdata)
  );

  qfts_ram #(.WIDTH(DATA_WIDTH), .DEPTH(STACK_DEPTH)) u_out_stack (
    .clk   (clk),
    .we    (out_we),
    .waddr (out_waddr),
    .wdata (in_rdata),
    .raddr (out_raddr),
    .rdata (out_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    in_cnt_nxt    = in_cnt_r;
    out_cnt_nxt   = out_cnt_r;
    mv_pend_nxt   = 1'b0;
    out_valid_nxt = 1'b0;
    out_item_nxt  = '0;
    cmd_pop       = 1'b0;
    in_we         = 1'b0;
    out_we        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop   = 1'b1;
          cmd_nxt   = cmd;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd_r.op == OP_ENQ) begin
          if (!in_full) begin
            in_we                    = 1'b1;
            in_cnt_nxt               = in_cnt_r + 1'b1;
            out_valid_nxt            = 1'b1;
            out_item_nxt.status      = ST_DONE;
            out_item_nxt.queue_empty = 1'b0;
            state_nxt                = S_IDLE;
          end else if (out_cnt_r != '0) begin
            out_valid_nxt            = 1'b1;
            out_item_nxt.status      = ST_FULL;
            out_item_nxt.queue_empty = 1'b0;
            state_nxt                = S_IDLE;
          end else begin
            state_nxt = S_MOVE;
          end
        end else begin
          if (out_cnt_r != '0) begin
            out_cnt_nxt = out_cnt_r - 1'b1;
            state_nxt   = S_POP;
          end else if (in_cnt_r != '0) begin
            state_nxt = S_MOVE;
          end else begin
            out_valid_nxt            = 1'b1;
            out_item_nxt.status      = ST_EMPTY;
            out_item_nxt.queue_empty = 1'b1;
            state_nxt                = S_IDLE;
          end
        end
      end
      S_MOVE: begin
        // read of the input top overlaps the write of the entry read last cycle
        if (mv_pend_r) begin
          out_we      = 1'b1;
          out_cnt_nxt = out_cnt_r + 1'b1;
        end
        if (in_cnt_r != '0) begin
          in_cnt_nxt  = in_cnt_r - 1'b1;
          mv_pend_nxt = 1'b1;
        end else if (!mv_pend_r) begin
          state_nxt = S_EXEC;
        end
      end
      S_POP: begin
        out_valid_nxt            = 1'b1;
        out_item_nxt.status      = ST_DONE;
        out_item_nxt.data_out    = 32'(out_rdata);
        out_item_nxt.queue_empty = (in_cnt_r == '0) && (out_cnt_r == '0);
        state_nxt                = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_cnt_r    <= '0;
      out_cnt_r   <= '0;
      mv_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_cnt_r    <= in_cnt_nxt;
      out_cnt_r   <= out_cnt_nxt;
      mv_pend_r   <= mv_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (in_cnt_r <= CW'(STACK_DEPTH)) && (out_cnt_r <= CW'(STACK_DEPTH)))
    else $error("stack count beyond depth");

  a_move_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && state_nxt == S_MOVE) |-> (out_cnt_r == '0 && in_cnt_r != '0))
    else $error("transfer started with output stack not empty");

  a_move_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOVE) |-> !in_we)
    else $error("input stack written during transfer");

  a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |=> (out_valid_r && out_item_r.status == ST_DONE))
    else $error("pop gave no result");

  a_empty_report: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.status == ST_EMPTY) |->
      (out_item_r.queue_empty && out_item_r.data_out == '0))
    else $error("empty refusal with bad fields");

endmodule

[rtl/queue_from_two_stacks.sv]
// FIFO built from an input stack and an output stack of STACK_DEPTH entries each.
// An item is accepted at a clock edge with start high and busy low; busy rises
// only while the two-entry command queue in front of the stack engine is full.
// Every item gives exactly one result, shown on out_item for one cycle with
// out_valid high; the receiver cannot stall, so results are never held back.
// A command is taken off the queue in S_IDLE and decoded in S_EXEC; an
// enqueue with room or a refusal gives its result from there, and a dequeue
// from a non-empty output stack goes on to S_POP. When the input stack has to
// be moved over first (enqueue on a full input stack with an empty output
// stack, or a dequeue on an empty output stack), the transfer sequencer in
// S_MOVE moves one entry per cycle, set by the single read port of the input
// stack RAM, and then returns to S_EXEC to decode the command again. Each
// entry is moved at most once.
// Stack contents are undefined after reset; no clearing pass is needed because
// the stack counts guard every read.
module queue_from_two_stacks
  import qfts_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  // command queue between front and stack engine
  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  // front: takes items, decodes the mode into an operation
  qfts_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // back: stack engine with both stack RAMs and the transfer sequencer
  qfts_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

[tb/sv/qfts_checker.sv]
module qfts_checker
  import qfts_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  out_item_t out_item,
  output int        fail_count,
  output int        results_due,
  output int        results_seen,
  output int        full_refusals,
  output int        empty_refusals,
  output int        transfers
);

  localparam int DEPTH = STACK_DEPTH_DEF;

  // shadow of the two stacks
  logic [31:0] in_stk  [DEPTH];
  logic [31:0] out_stk [DEPTH];
  int          in_cnt;
  int          out_cnt;

  out_item_t   due_q [$];
  int          n_fail, n_seen, n_full, n_empty, n_move;

  initial begin
    in_cnt  = 0;
    out_cnt = 0;
    n_fail  = 0;
    n_seen  = 0;
    n_full  = 0;
    n_empty = 0;
    n_move  = 0;
  end

  // reverse the input stack into the empty output stack
  function automatic void move_over();
    if (in_cnt > 0) n_move++;
    while (in_cnt > 0 && out_cnt < DEPTH) begin
      in_cnt--;
      out_stk[out_cnt] = in_stk[in_cnt];
      out_cnt++;
    end
  endfunction

  function automatic out_item_t two_stack_step(in_item_t it);
    out_item_t r;
    r.status   = ST_DONE;
    r.data_out = '0;
    if (op_t'(it.mode) == OP_ENQ) begin
      if (in_cnt >= DEPTH) begin
        if (out_cnt != 0) r.status = ST_FULL;
        else move_over();
      end
      if (r.status == ST_DONE && in_cnt < DEPTH) begin
        in_stk[in_cnt] = it.data_in;
        in_cnt++;
      end
    end else begin
      if (out_cnt == 0) move_over();
      if (out_cnt == 0) begin
        r.status = ST_EMPTY;
      end else begin
        out_cnt--;
        r.data_out = out_stk[out_cnt];
      end
    end
    if (r.status == ST_FULL) n_full++;
    if (r.status == ST_EMPTY) n_empty++;
    r.queue_empty = (in_cnt == 0 && out_cnt == 0);
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
    n_fail++;
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      in_cnt  = 0;
      out_cnt = 0;
      due_q.delete();
    end else begin
      // results first: none can belong to an item taken at this same edge
      if (out_valid) begin
        n_seen++;
        if (due_q.size() == 0) begin
          n_fail++;
          $display("%0t: result with nothing expected, expected none, actual %h",
                   $time, out_item);
        end else begin
          want = due_q.pop_front();
          if (out_item.status !== want.status)
            report_mismatch("status", 32'(want.status), 32'(out_item.status));
          if (out_item.data_out !== want.data_out)
            report_mismatch("data_out", want.data_out, out_item.data_out);
          if (out_item.queue_empty !== want.queue_empty)
            report_mismatch("queue_empty", 32'(want.queue_empty),
                            32'(out_item.queue_empty));
        end
      end
      if (start && !busy) due_q.push_back(two_stack_step(in_item));
    end
    fail_count     <= n_fail;
    results_due    <= due_q.size();
    results_seen   <= n_seen;
    full_refusals  <= n_full;
    empty_refusals <= n_empty;
    transfers      <= n_move;
  end

endmodule

[tb/sv/tb_queue_from_two_stacks.sv]
module tb_queue_from_two_stacks;
  import qfts_pkg::*;

  localparam int RAND_ITEMS  = 2000;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 40;   // longer than a full transfer plus a dequeue

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  int fail_count, results_due, results_seen;
  int full_refusals, empty_refusals, transfers;
  int cycle_count;
  int n_items;
  int n_directed;

  queue_from_two_stacks DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // watches both channels, predicts and compares
  qfts_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_item       (out_item),
    .fail_count     (fail_count),
    .results_due    (results_due),
    .results_seen   (results_seen),
    .full_refusals  (full_refusals),
    .empty_refusals (empty_refusals),
    .transfers      (transfers)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // watchdog against a hung handshake
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("TB_ERROR");
      $finish;
    end
  end

  // mostly back to back or short gaps, now and then a long one
  function automatic int pick_gap(input bit idle_on);
    int roll;
    roll = $urandom_range(0, 99);
    if (!idle_on || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // data with extra weight on all zeros and all ones
  function automatic logic [31:0] pick_data();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 32'h0000_0000;
    if (roll == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // hold start high until the item is taken; start stays high into the
  // next item when there is no gap, so it is never lowered and raised in one step
  task automatic issue(input op_t op, input logic [31:0] d, input int gap);
    start   <= 1'b1;
    in_item <= '{mode: op, data_in: d};
    @(posedge clk);
    while (busy) @(posedge clk);
    n_items++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    int phase_len;
    int enq_pct;
    bit idle_on;
    op_t op;

    n_items = 0;
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_item <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: dequeue on an empty queue is refused, data ignored
    issue(OP_DEQ, 32'hFFFF_FFFF, pick_gap(1'b1));
    // extremes of the data field
    issue(OP_ENQ, 32'h0000_0000, pick_gap(1'b1));
    issue(OP_ENQ, 32'hFFFF_FFFF, pick_gap(1'b1));
    // dequeue with empty output stack moves the two entries over
    issue(OP_DEQ, 32'hA5A5_A5A5, pick_gap(1'b1));
    // fill the input stack while the output stack still holds one
    for (int i = 0; i < STACK_DEPTH_DEF; i++)
      issue(OP_ENQ, (i % 2) ? ~(32'h1 << i) : (32'h1 << (31 - i)), pick_gap(1'b0));
    // input full and output not empty: refused as full
    issue(OP_ENQ, 32'h5555_5555, pick_gap(1'b1));
    // drain the output stack
    issue(OP_DEQ, 32'h0000_0000, pick_gap(1'b1));
    // input full and output empty: transfer, then the push goes through
    issue(OP_ENQ, 32'hAAAA_AAAA, pick_gap(1'b1));
    issue(OP_DEQ, 32'hFFFF_FFFF, pick_gap(1'b1));
    issue(OP_DEQ, 32'h0000_0000, pick_gap(1'b1));
    n_directed = n_items;

    // random: phases that lean toward enqueue, dequeue or neither so the
    // queue swings between full and empty; some phases run with no idling
    while (n_items - n_directed < RAND_ITEMS) begin
      phase_len = $urandom_range(8, 60);
      case ($urandom_range(0, 2))
        0: enq_pct = 85;
        1: enq_pct = 15;
        default: enq_pct = 50;
      endcase
      idle_on = ($urandom_range(0, 3) != 0);
      repeat (phase_len) begin
        op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
        issue(op, pick_data(), pick_gap(idle_on));
      end
    end
    start <= 1'b0;

    // drain, then a tail for anything the block might still emit
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d items (%0d directed), %0d results checked, %0d stack transfers",
             n_items, n_directed, results_seen, transfers);
    $display("refusals seen: %0d on a full queue, %0d on an empty queue",
             full_refusals, empty_refusals);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
